@@ rtl/linear_array_deque_unit_macros.svh @@
// assertion macros of the deque unit top module
`ifndef LINEAR_ARRAY_DEQUE_UNIT_MACROS_SVH
`define LINEAR_ARRAY_DEQUE_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define LDQ_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LDQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ldq_pkg.sv @@
// shared codes, widths and types of the linear array deque unit
package ldq_pkg;

    // field widths
    localparam int REQ_W    = 3;
    localparam int DATA_W   = 32;
    localparam int OFF_W    = 4;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;
    localparam int CAP_W    = 5;

    // capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ       = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FRONT_TAKEN = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BACK_LIMIT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OFF_RANGE   = 3'd4;

    // entry store access strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

@@ rtl/ldq_store.sv @@
// entry store of the deque: one write port, one registered read port
module ldq_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                       aclk,
    input  ldq_pkg::mem_ctl_t          mem_ctl,
    input  logic [AW-1:0]              wr_addr,
    input  logic [ldq_pkg::DATA_W-1:0] wr_data,
    input  logic [AW-1:0]              rd_addr,
    output logic [ldq_pkg::DATA_W-1:0] rd_data
);

    logic [ldq_pkg::DATA_W-1:0] mem [DEPTH];
    logic [ldq_pkg::DATA_W-1:0] rd_data_reg;

    // write on push
    always_ff @(posedge aclk) begin
        if (mem_ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read on read request
    always_ff @(posedge aclk) begin
        if (mem_ctl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/ldq_ctrl.sv @@
// front/back pointers, capacity register and per-request decision logic
module ldq_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // capacity write
    input  logic                         cap_we,
    input  logic [ldq_pkg::CAP_W-1:0]    cap_data,
    // request at accept
    input  logic                         req_fire,
    input  logic [ldq_pkg::REQ_W-1:0]    req_type,
    input  logic [ldq_pkg::DATA_W-1:0]   data_value,
    input  logic [ldq_pkg::OFF_W-1:0]    read_offset,
    // entry store access
    output ldq_pkg::mem_ctl_t            mem_ctl,
    output logic [AW-1:0]                wr_addr,
    output logic [ldq_pkg::DATA_W-1:0]   wr_data,
    output logic [AW-1:0]                rd_addr,
    // result of the request
    output logic [ldq_pkg::STATUS_W-1:0] status,
    output logic [ldq_pkg::COUNT_W-1:0]  item_count
);

    // wide enough for counts, offsets and the capacity
    localparam int CNTW = (AW + 1 > ldq_pkg::COUNT_W) ? AW + 1 : ldq_pkg::COUNT_W;

    logic [AW-1:0]               front_reg, front_next;
    logic [AW-1:0]               back_reg, back_next;
    logic                        holds_reg, holds_next;
    logic [ldq_pkg::CAP_W-1:0]   cap_reg;

    logic [CNTW-1:0] cnt_now;
    logic [CNTW-1:0] cnt_after;
    logic [CNTW-1:0] cap_eff;
    logic [CNTW-1:0] back_limit;
    logic [CNTW-1:0] rd_pos;
    logic            wr_en;
    logic            rd_en;

    // capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= ldq_pkg::CAP_RESET;
        end else if (cap_we) begin
            cap_reg <= cap_data;
        end
    end

    // clamp capacity into 1..DEPTH
    always_comb begin
        cap_eff = CNTW'(cap_reg);
        if (cap_reg == '0) begin
            cap_eff = CNTW'(1);
        end
        if (cap_eff > CNTW'(DEPTH)) begin
            cap_eff = CNTW'(DEPTH);
        end
        back_limit = cap_eff - CNTW'(1);
    end

    // items held before the request
    assign cnt_now = holds_reg ? (CNTW'(back_reg) - CNTW'(front_reg) + CNTW'(1)) : '0;
    assign rd_pos  = CNTW'(front_reg) + CNTW'(read_offset);

    // request decode
    always_comb begin
        front_next = front_reg;
        back_next  = back_reg;
        holds_next = holds_reg;
        status     = ldq_pkg::ST_OK;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        wr_addr    = front_reg;
        case (req_type)
            ldq_pkg::REQ_PUSH_FRONT: begin
                if (!holds_reg) begin
                    front_next = '0;
                    back_next  = '0;
                    holds_next = 1'b1;
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                end else if (front_reg == '0) begin
                    status = ldq_pkg::ST_FRONT_TAKEN;
                end else begin
                    front_next = front_reg - AW'(1);
                    wr_en      = 1'b1;
                    wr_addr    = front_reg - AW'(1);
                end
            end
            ldq_pkg::REQ_PUSH_BACK: begin
                if (!holds_reg) begin
                    front_next = '0;
                    back_next  = '0;
                    holds_next = 1'b1;
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                end else if (CNTW'(back_reg) >= back_limit) begin
                    status = ldq_pkg::ST_BACK_LIMIT;
                end else begin
                    back_next = back_reg + AW'(1);
                    wr_en     = 1'b1;
                    wr_addr   = back_reg + AW'(1);
                end
            end
            ldq_pkg::REQ_POP_FRONT: begin
                if (!holds_reg) begin
                    status = ldq_pkg::ST_EMPTY;
                end else if (front_reg == back_reg) begin
                    front_next = '0;
                    back_next  = '0;
                    holds_next = 1'b0;
                end else begin
                    front_next = front_reg + AW'(1);
                end
            end
            ldq_pkg::REQ_POP_BACK: begin
                if (!holds_reg) begin
                    status = ldq_pkg::ST_EMPTY;
                end else if (front_reg == back_reg) begin
                    front_next = '0;
                    back_next  = '0;
                    holds_next = 1'b0;
                end else begin
                    back_next = back_reg - AW'(1);
                end
            end
            ldq_pkg::REQ_READ: begin
                if (!holds_reg) begin
                    status = ldq_pkg::ST_EMPTY;
                end else if (CNTW'(read_offset) >= cnt_now) begin
                    status = ldq_pkg::ST_OFF_RANGE;
                end else begin
                    rd_en = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // items held after the request
    assign cnt_after  = holds_next ? (CNTW'(back_next) - CNTW'(front_next) + CNTW'(1)) : '0;
    assign item_count = cnt_after[ldq_pkg::COUNT_W-1:0];

    // store strobes only on an accepted transaction
    assign mem_ctl.wr_en = wr_en & req_fire;
    assign mem_ctl.rd_en = rd_en & req_fire;
    assign wr_data       = data_value;
    assign rd_addr       = rd_pos[AW-1:0];

    // pointer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            back_reg  <= '0;
            holds_reg <= 1'b0;
        end else if (req_fire) begin
            front_reg <= front_next;
            back_reg  <= back_next;
            holds_reg <= holds_next;
        end
    end

endmodule

@@ rtl/linear_array_deque_unit.sv @@
// Linear array deque unit: a double-ended queue in a fixed array of DEPTH
// entries with no wraparound. Each request on the slave stream (s_tuser holds
// the request kind) pushes at the front or back, pops at the front or back,
// or reads the entry at an offset from the front; one result per request
// leaves on the master stream with a status code in m_tuser. A front push
// fails once position 0 is taken, a back push fails at capacity-1, and pops
// or reads on an empty queue report empty. The unit takes one transaction per
// clock, holding the slave side only while the output register is full and not
// taken; each result appears in the cycle after its request is accepted, set by
// the single pointer-update pass and the one registered read of the entry
// memory. The user must write the capacity register (reset 16) only while
// idle (unenforced), via cfg_valid/cfg_data; values outside 1..DEPTH clamp.
// Entries never written read as undefined but cannot be reached by a read.
module linear_array_deque_unit #(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // capacity write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,     // capacity
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,      // data_value[31:0], read_offset[35:32], zero pad
    input  logic [2:0]  s_tuser,      // req_type[2:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,      // read_value[31:0], item_count[36:32], zero pad
    output logic [2:0]  m_tuser       // status[2:0]
);

`include "linear_array_deque_unit_macros.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                          s_fire;
    ldq_pkg::mem_ctl_t             mem_ctl;
    logic [AW-1:0]                 wr_addr;
    logic [AW-1:0]                 rd_addr;
    logic [ldq_pkg::DATA_W-1:0]    wr_data;
    logic [ldq_pkg::DATA_W-1:0]    rd_data;
    logic [ldq_pkg::STATUS_W-1:0]  status;
    logic [ldq_pkg::COUNT_W-1:0]   item_count;

    logic                          m_valid_reg;
    logic [ldq_pkg::STATUS_W-1:0]  status_reg;
    logic [ldq_pkg::COUNT_W-1:0]   count_reg;
    logic                          rd_ok_reg;
    logic [ldq_pkg::DATA_W-1:0]    read_value;

    // handshakes
    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;

    // pointer and decision logic
    ldq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cap_we      (cfg_valid && cfg_ready),
        .cap_data    (cfg_data),
        .req_fire    (s_fire),
        .req_type    (s_tuser),
        .data_value  (s_tdata[31:0]),
        .read_offset (s_tdata[35:32]),
        .mem_ctl     (mem_ctl),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_addr     (rd_addr),
        .status      (status),
        .item_count  (item_count)
    );

    // entry memory
    ldq_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .mem_ctl (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            status_reg <= status;
            count_reg  <= item_count;
            rd_ok_reg  <= mem_ctl.rd_en;
        end
    end

    assign read_value = rd_ok_reg ? rd_data : '0;
    assign m_tvalid   = m_valid_reg;
    assign m_tuser    = status_reg;
    assign m_tdata    = {3'b000, count_reg, read_value};

    // checks
    `LDQ_ASSERT_NEXT(a_fire_gives_result, aclk, aresetn, s_fire, m_tvalid,
        "accepted request produced no result")
    `LDQ_ASSERT_IMPL(a_fail_reads_zero, aclk, aresetn,
        m_tvalid && (m_tuser != ldq_pkg::ST_OK), m_tdata[31:0] == '0,
        "failed request returned a nonzero read value")
    `LDQ_ASSERT_IMPL(a_empty_count_zero, aclk, aresetn,
        m_tvalid && (m_tuser == ldq_pkg::ST_EMPTY), m_tdata[36:32] == '0,
        "empty status with nonzero item count")
    `LDQ_ASSERT_IMPL(a_range_count_nonzero, aclk, aresetn,
        m_tvalid && (m_tuser == ldq_pkg::ST_OFF_RANGE), m_tdata[36:32] != '0,
        "offset out of range reported on an empty queue")
    `LDQ_ASSERT_IMPL(a_count_bound, aclk, aresetn, m_tvalid,
        (DEPTH > 31) || (int'(m_tdata[36:32]) <= DEPTH),
        "item count above depth")

endmodule
